@@ rtl/jvbi_pkg.sv @@
package jvbi_pkg;

  // Fixed-point format of positions, velocities and factors
  localparam int FRAC_BITS = 16;
  localparam logic signed [17:0] ONE_FIX = 18'sd65536;

  // Register map (word index)
  localparam logic REG_DT   = 1'b0;
  localparam logic REG_STEP = 1'b1;

  // Reset values of the registers
  localparam logic [15:0]        DT_RESET   = 16'd655;
  localparam logic signed [17:0] STEP_RESET = ONE_FIX;

  // Square root: radicand width, root width, remainder width, number of stages
  localparam int SQ_IN_W   = 64;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_REM_W  = 36;
  localparam int SQ_STAGES = 16;

  typedef enum logic [1:0] {
    CODE_POS = 2'd0,
    CODE_ACC = 2'd1,
    CODE_BRK = 2'd2
  } code_t;

  // Per-item values that ride alongside the square root
  typedef struct packed {
    logic signed [33:0] acc_up;
    logic signed [33:0] acc_dn;
    logic signed [32:0] room_hi;
    logic signed [32:0] room_lo;
    logic               v_pos;
    logic               v_neg;
    logic               neg;
  } side_t;

endpackage

@@ rtl/jvbi_front.sv @@
module jvbi_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   position_offset,
  input  logic signed [31:0]   prev_velocity,
  input  logic signed [31:0]   limit_high,
  input  logic signed [31:0]   limit_low,
  input  logic [30:0]          accel_limit,
  input  logic [15:0]          dt_step,
  input  logic signed [17:0]   step_ahead,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [46:0]          out_m,
  output jvbi_pkg::side_t      out_side
);
  import jvbi_pkg::*;

  // Stage A: captured request
  logic               a_vld;
  logic signed [31:0] a_q, a_v, a_hi, a_lo;
  logic [30:0]        a_acc;
  // Stage B
  logic               b_vld;
  logic [46:0]        b_accdt;
  logic signed [32:0] b_dv, b_room_hi, b_room_lo;
  logic               b_v_pos, b_v_neg;
  // Stage C
  logic               c_vld;
  logic [30:0]        c_a2;
  logic signed [32:0] c_dv, c_room_hi, c_room_lo;
  logic               c_v_pos, c_v_neg;
  // Stage D
  logic               d_vld;
  logic [31:0]        d_a2p;
  logic [32:0]        d_rm;
  side_t              d_side;
  // Stage E
  logic               e_vld;
  logic [46:0]        e_m;
  side_t              e_side;

  logic adv_a, adv_b, adv_c, adv_d, adv_e;

  // Advance a stage when it is empty or its successor moves on
  assign adv_e = !e_vld || out_ready;
  assign adv_d = !d_vld || adv_e;
  assign adv_c = !c_vld || adv_d;
  assign adv_b = !b_vld || adv_c;
  assign adv_a = !a_vld || adv_b;
  assign in_ready = adv_a;

  // A to B: first products and the room to each limit
  logic [31:0]        vmag;
  logic [47:0]        dvprod;
  logic [31:0]        dvm;
  logic [46:0]        accdt;
  logic signed [32:0] dv, room_hi, room_lo;

  always_comb begin
    vmag    = a_v[31] ? 32'(-a_v) : 32'(a_v);
    dvprod  = 48'(vmag) * 48'(dt_step);
    dvm     = dvprod[47:16];
    dv      = a_v[31] ? -$signed({1'b0, dvm}) : $signed({1'b0, dvm});
    accdt   = 47'(a_acc) * 47'(dt_step);
    room_hi = $signed({a_hi[31], a_hi}) - $signed({a_q[31], a_q});
    room_lo = $signed({a_lo[31], a_lo}) - $signed({a_q[31], a_q});
  end

  // B to C: acceleration step a*dt^2
  logic [62:0] a2full;
  assign a2full = 63'(b_accdt) * 63'(dt_step);

  // C to D: scaled acceleration, reachable steps, braking room
  logic [17:0]        pmag;
  logic [48:0]        a2pfull;
  logic signed [32:0] room_sel;
  side_t              side_c;

  always_comb begin
    pmag     = step_ahead[17] ? 18'(-step_ahead) : 18'(step_ahead);
    a2pfull  = 49'(c_a2) * 49'(pmag);
    room_sel = c_v_pos ? c_room_hi : c_room_lo;
    side_c.acc_up  = $signed({c_dv[32], c_dv}) + $signed({3'b000, c_a2});
    side_c.acc_dn  = $signed({c_dv[32], c_dv}) - $signed({3'b000, c_a2});
    side_c.room_hi = c_room_hi;
    side_c.room_lo = c_room_lo;
    side_c.v_pos   = c_v_pos;
    side_c.v_neg   = c_v_neg;
    side_c.neg     = step_ahead[17] ^ room_sel[32];
  end

  // D to E: product of scaled acceleration and room
  logic [64:0] prod;
  assign prod = 65'(d_a2p) * 65'(d_rm);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else begin
      if (adv_a) a_vld <= in_valid;
      if (adv_b) b_vld <= a_vld;
      if (adv_c) c_vld <= b_vld;
      if (adv_d) d_vld <= c_vld;
      if (adv_e) e_vld <= d_vld;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_q   <= position_offset;
      a_v   <= prev_velocity;
      a_hi  <= limit_high;
      a_lo  <= limit_low;
      a_acc <= accel_limit;
    end
    if (adv_b) begin
      b_accdt   <= accdt;
      b_dv      <= dv;
      b_room_hi <= room_hi;
      b_room_lo <= room_lo;
      b_v_pos   <= !a_v[31] && (a_v != 32'sd0);
      b_v_neg   <= a_v[31];
    end
    if (adv_c) begin
      c_a2      <= a2full[62:32];
      c_dv      <= b_dv;
      c_room_hi <= b_room_hi;
      c_room_lo <= b_room_lo;
      c_v_pos   <= b_v_pos;
      c_v_neg   <= b_v_neg;
    end
    if (adv_d) begin
      d_a2p  <= a2pfull[47:16];
      d_rm   <= room_sel[32] ? 33'(-room_sel) : 33'(room_sel);
      d_side <= side_c;
    end
    // Flag any product of 2^62 or more in the top bit so the root saturates
    if (adv_e) begin
      e_m    <= {|prod[64:62], prod[61:16]};
      e_side <= d_side;
    end
  end

  assign out_valid = e_vld;
  assign out_m     = e_m;
  assign out_side  = e_side;

endmodule

@@ rtl/jvbi_sqrt.sv @@
module jvbi_sqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [46:0]                        in_m,
  input  jvbi_pkg::side_t                    in_side,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [jvbi_pkg::SQ_ROOT_W-1:0]     out_root,
  output jvbi_pkg::side_t                    out_side
);
  import jvbi_pkg::*;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_IN_W-1:0]   n;
  } sq_t;

  // Resolve two root bits from the top of the remaining radicand
  function automatic sq_t sq_step2(input sq_t s);
    sq_t                 r;
    logic [SQ_REM_W-1:0] trial;
    r = s;
    for (int i = 0; i < 2; i++) begin
      r.rem = {r.rem[SQ_REM_W-3:0], r.n[SQ_IN_W-1 -: 2]};
      r.n   = {r.n[SQ_IN_W-3:0], 2'b00};
      trial = {2'b00, r.root, 2'b01};
      if (r.rem >= trial) begin
        r.rem  = r.rem - trial;
        r.root = {r.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [SQ_STAGES-1:0] vld;
  logic [SQ_STAGES-1:0] adv;
  sq_t                  st   [SQ_STAGES];
  side_t                side [SQ_STAGES];
  sq_t                  nxt  [SQ_STAGES];

  // Saturate the doubled term and scale it into the radicand
  logic [46:0] msat;
  sq_t         head;

  always_comb begin
    msat      = in_m[46] ? {47{1'b1}} : {in_m[45:0], 1'b0};
    head.rem  = '0;
    head.root = '0;
    head.n    = {1'b0, msat, 16'd0};
  end

  // Advance chain, last stage first
  always_comb begin
    adv[SQ_STAGES-1] = !vld[SQ_STAGES-1] || out_ready;
    for (int k = SQ_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end
  assign in_ready = adv[0];

  // Next state of each stage
  always_comb begin
    nxt[0] = sq_step2(head);
    for (int k = 1; k < SQ_STAGES; k++) begin
      nxt[k] = sq_step2(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < SQ_STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0]   <= nxt[0];
      side[0] <= in_side;
    end
    for (int k = 1; k < SQ_STAGES; k++) begin
      if (adv[k]) begin
        st[k]   <= nxt[k];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign out_root  = st[SQ_STAGES-1].root;
  assign out_side  = side[SQ_STAGES-1];

endmodule

@@ rtl/jvbi_back.sv @@
module jvbi_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [jvbi_pkg::SQ_ROOT_W-1:0] in_root,
  input  jvbi_pkg::side_t                in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             bound_low,
  output logic signed [31:0]             bound_high,
  output logic [1:0]                     active_low,
  output logic [1:0]                     active_high
);
  import jvbi_pkg::*;

  function automatic logic [31:0] sat32(input logic signed [33:0] x);
    logic [31:0] r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) r = x[31:0];
    else if (x[33]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

  logic signed [33:0] via, ub, lb, ub_f, lb_f;
  code_t              cu, cl, cu_f, cl_f;
  logic               vld;

  // Pick each bound and its constraint, then order them
  always_comb begin
    via = in_side.neg ? -$signed({2'b00, in_root}) : $signed({2'b00, in_root});
    if (!in_side.v_pos) begin
      if ($signed({in_side.room_hi[32], in_side.room_hi}) < in_side.acc_up) begin
        ub = $signed({in_side.room_hi[32], in_side.room_hi});
        cu = CODE_POS;
      end else begin
        ub = in_side.acc_up;
        cu = CODE_ACC;
      end
    end else begin
      if (via < in_side.acc_up) begin
        ub = via;
        cu = CODE_BRK;
      end else begin
        ub = in_side.acc_up;
        cu = CODE_ACC;
      end
    end
    if (!in_side.v_neg) begin
      if ($signed({in_side.room_lo[32], in_side.room_lo}) > in_side.acc_dn) begin
        lb = $signed({in_side.room_lo[32], in_side.room_lo});
        cl = CODE_POS;
      end else begin
        lb = in_side.acc_dn;
        cl = CODE_ACC;
      end
    end else begin
      if (via > in_side.acc_dn) begin
        lb = via;
        cl = CODE_BRK;
      end else begin
        lb = in_side.acc_dn;
        cl = CODE_ACC;
      end
    end
    // Swap crossed bounds together with their codes
    if (lb > ub) begin
      lb_f = ub;
      ub_f = lb;
      cl_f = cu;
      cu_f = cl;
    end else begin
      lb_f = lb;
      ub_f = ub;
      cl_f = cl;
      cu_f = cu;
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      bound_low   <= sat32(lb_f);
      bound_high  <= sat32(ub_f);
      active_low  <= cl_f;
      active_high <= cu_f;
    end
  end

  assign out_valid = vld;

endmodule

@@ rtl/joint_velocity_bound_invariance_top.sv @@
// Joint step bounds for position-limit invariance. One joint is accepted per
// cycle; each passes through five arithmetic stages (products of acceleration,
// period and step-ahead factor, then the braking product), a 16-stage square
// root that resolves two root bits per stage, and a registered output stage.
// Every stage holds its request under a stall and empty stages fill while the
// output waits, so the full rate is kept whenever the consumer takes results.
// dt_step (address 0) and step_ahead (address 4) are to be written over the APB
// port only while no joint is in flight; the block does not enforce this. A
// step_ahead write above 1.0 is dropped.
module joint_velocity_bound_invariance_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] position_offset,
  input  logic signed [31:0] prev_velocity,
  input  logic signed [31:0] limit_high,
  input  logic signed [31:0] limit_low,
  input  logic [30:0]        accel_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] bound_low,
  output logic signed [31:0] bound_high,
  output logic [1:0]         active_low,
  output logic [1:0]         active_high,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import jvbi_pkg::*;

  logic [15:0]        dt_step;
  logic signed [17:0] step_ahead;
  logic signed [17:0] wr_step;
  logic               wr_en;

  // Register writes and reads
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_step = $signed(pwdata[17:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_step    <= DT_RESET;
      step_ahead <= STEP_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DT:   dt_step <= pwdata[15:0];
        REG_STEP: if (wr_step <= ONE_FIX) step_ahead <= wr_step;
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DT:   prdata = {16'd0, dt_step};
      REG_STEP: prdata = {{14{step_ahead[17]}}, step_ahead};
      default:  prdata = '0;
    endcase
  end

  // Datapath
  logic        f_valid, f_ready;
  logic [46:0] f_m;
  side_t       f_side;
  logic        s_valid, s_ready;
  logic [SQ_ROOT_W-1:0] s_root;
  side_t       s_side;

  jvbi_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .position_offset (position_offset),
    .prev_velocity   (prev_velocity),
    .limit_high      (limit_high),
    .limit_low       (limit_low),
    .accel_limit     (accel_limit),
    .dt_step         (dt_step),
    .step_ahead      (step_ahead),
    .out_valid       (f_valid),
    .out_ready       (f_ready),
    .out_m           (f_m),
    .out_side        (f_side)
  );

  jvbi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_m      (f_m),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  jvbi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_valid),
    .in_ready    (s_ready),
    .in_root     (s_root),
    .in_side     (s_side),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bound_low   (bound_low),
    .bound_high  (bound_high),
    .active_low  (active_low),
    .active_high (active_high)
  );

  // The step-ahead factor never exceeds 1.0
  a_step_cap: assert property (@(posedge clk) disable iff (rst)
    step_ahead <= ONE_FIX)
    else $error("step_ahead above 1.0");

  // Delivered bounds are ordered
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bound_low <= bound_high)
    else $error("crossed bounds delivered");

  // Only defined constraint codes are delivered
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (active_low != 2'd3 && active_high != 2'd3))
    else $error("undefined constraint code");

  // The pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

@@ test/joint_velocity_bound_invariance_top_tb.sv @@
module joint_velocity_bound_invariance_top_tb;
  import jvbi_pkg::*;

  localparam int LATENCY = 22;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] ROOT_CAP = (64'd1 << (63 - FRAC_BITS)) - 64'd1;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    code_t              code_lo;
    code_t              code_hi;
  } bounds_t;

  // Joint bound predictor with its own copy of the registers
  class bound_board;
    logic [15:0]        dt;
    logic signed [17:0] p;
    bounds_t            pending[$];
    int                 errors;

    function void reset_regs();
      dt = DT_RESET;
      p  = STEP_RESET;
    endfunction

    // The word index sits in address bit 2; the byte offset is ignored
    function void write_reg(logic [2:0] addr, logic [31:0] data);
      logic signed [17:0] np;
      np = data[17:0];
      if (addr[2] == REG_DT) dt = data[15:0];
      else if (addr[2] == REG_STEP && np <= ONE_FIX) p = np;
    endfunction

    function logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [63:0] braking(logic [63:0] a2p, logic signed [63:0] room);
      logic [63:0] rm, m, s;
      logic [127:0] prod;
      logic neg;
      rm = room < 0 ? -room : room;
      neg = (p < 0) != (room < 0);
      prod = a2p * rm;
      if (prod[127:64] != 0) prod = 128'(64'hFFFF_FFFF_FFFF_FFFF);
      m = prod[63:0] >> FRAC_BITS;
      if (m > ROOT_CAP / 2) m = ROOT_CAP;
      else m = 2 * m;
      s = isqrt(m << FRAC_BITS);
      return neg ? -$signed(s) : $signed(s);
    endfunction

    function logic signed [31:0] sat(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
    endfunction

    function void note_request(logic signed [31:0] q, logic signed [31:0] v,
                               logic signed [31:0] lh, logic signed [31:0] ll,
                               logic [30:0] acc);
      logic [63:0] a2, a2p, dvm, pm, vm;
      logic signed [63:0] dv, rh, rl, up, dn, ub, lb, t, via;
      code_t cu, cl, tc;
      bounds_t e;
      a2  = (64'(acc) * dt * dt) >> (2 * FRAC_BITS);
      pm  = p < 0 ? 64'(-p) : 64'(p);
      a2p = (a2 * pm) >> FRAC_BITS;
      vm  = v < 0 ? 64'(-64'(v)) : 64'(v);
      dvm = (vm * dt) >> FRAC_BITS;
      dv  = v < 0 ? -$signed(dvm) : $signed(dvm);
      rh  = 64'(lh) - 64'(q);
      rl  = 64'(ll) - 64'(q);
      up  = dv + $signed(a2);
      dn  = dv - $signed(a2);
      if (v <= 0) begin
        if (rh < up) begin ub = rh; cu = CODE_POS; end
        else begin ub = up; cu = CODE_ACC; end
      end else begin
        via = braking(a2p, rh);
        if (via < up) begin ub = via; cu = CODE_BRK; end
        else begin ub = up; cu = CODE_ACC; end
      end
      if (v >= 0) begin
        if (rl > dn) begin lb = rl; cl = CODE_POS; end
        else begin lb = dn; cl = CODE_ACC; end
      end else begin
        via = braking(a2p, rl);
        if (via > dn) begin lb = via; cl = CODE_BRK; end
        else begin lb = dn; cl = CODE_ACC; end
      end
      // Swap crossed bounds with their codes
      if (lb > ub) begin
        t = lb; lb = ub; ub = t;
        tc = cl; cl = cu; cu = tc;
      end
      e.lo = sat(lb);
      e.hi = sat(ub);
      e.code_lo = cl;
      e.code_hi = cu;
      pending.push_back(e);
    endfunction

    function void check_result(bounds_t got);
      bounds_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected lo=%0d hi=%0d cl=%0d ch=%0d, ",
                    "got lo=%0d hi=%0d cl=%0d ch=%0d"},
                   e.lo, e.hi, e.code_lo, e.code_hi,
                   got.lo, got.hi, got.code_lo, got.code_hi);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] position_offset, prev_velocity, limit_high, limit_low;
  logic [30:0] accel_limit;
  logic signed [31:0] bound_low, bound_high;
  logic [1:0] active_low, active_high;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  bound_board board;
  int cycles;
  bit hold_off;

  joint_velocity_bound_invariance_top dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off
  initial begin
    out_ready = 0;
    hold_off = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        board.check_result({bound_low, bound_high, code_t'(active_low), code_t'(active_high)});
      if (hold_off) out_ready <= 0;
      else if ((cycles / 300) % 3 == 0) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    board.write_reg(addr, data);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_joint(logic signed [31:0] q, logic signed [31:0] v,
                            logic signed [31:0] lh, logic signed [31:0] ll,
                            logic [30:0] acc);
    in_valid <= 1;
    position_offset <= q; prev_velocity <= v;
    limit_high <= lh; limit_low <= ll; accel_limit <= acc;
    do @(posedge clk); while (!in_ready);
    board.note_request(q, v, lh, ll, acc);
  endtask

  task automatic pause_sender();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  task automatic random_joints(int count);
    int burst;
    logic signed [31:0] q;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      q = rand_val();
      send_joint(q, rand_val(),
                 $urandom_range(0, 3) == 0 ? rand_val() : q + $urandom_range(0, 1 << 22),
                 $urandom_range(0, 3) == 0 ? rand_val() : q - $urandom_range(0, 1 << 22),
                 $urandom_range(0, 2) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 24)));
      if (--burst == 0) begin
        if ($urandom_range(0, 1)) pause_sender();
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  initial begin
    logic [15:0] dts[5];
    logic [31:0] steps[6];
    board = new();
    board.reset_regs();
    board.errors = 0;
    dts = '{16'd0, 16'hFFFF, 16'd655, 16'd6554, 16'd30000};
    steps = '{32'h0001_0000, 32'h0003_0000, 32'h0003_8000, 32'h0000_8000, 32'h0000_0000,
              32'h0002_0001};
    rst = 1; in_valid = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    position_offset = 0; prev_velocity = 0; limit_high = 0; limit_low = 0; accel_limit = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, standing still, both directions, crossed limits
    send_joint(0, 0, 32'sd65536, -32'sd65536, 31'd65536);
    send_joint(0, 32'sd65536, 32'sd65536, -32'sd65536, 31'd655360);
    send_joint(0, -32'sd65536, 32'sd65536, -32'sd65536, 31'd655360);
    send_joint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_joint(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_joint(0, 32'sd100, 32'sd1000, -32'sd1000, 31'd0);
    send_joint(32'sd5000, 32'sd65536, 32'sd0, 32'sd10000, 31'd65536);
    send_joint(0, 32'sd3276800, 32'sd10, -32'sd10, 31'd1);
    send_joint(0, -32'sd3276800, 32'sd10, -32'sd10, 31'd1);
    send_joint(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFE, 31'h4000_0000);
    drain();

    // Hold the receiver off so the pipeline fills and stalls its input
    hold_off = 1;
    fork
      random_joints(60);
      begin repeat (200) @(posedge clk); hold_off = 0; end
    join
    drain();

    for (int k = 0; k < 6; k++) begin
      reg_write(3'(4 * REG_DT), {16'h0, dts[k % 5]});
      reg_write(3'(4 * REG_STEP), steps[k]);
      if (k == 2) reg_write(3'd7, 32'hFFFF_FFFF);
      random_joints(k == 5 ? 40 : 70);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
